FILE: rtl/lmts_pkg.sv
// lmts_pkg: shared types and timing constants for the lcd mode timing sequencer
// depends on nothing; used by lmts_core, lcd_mode_timing_sequencer and the testbench
package lmts_pkg;

  localparam int AccW  = 10;
  localparam int LineW = 8;
  localparam int CycW  = 7;

  localparam logic [AccW-1:0]  AccMax       = 10'd1023;
  localparam logic [AccW-1:0]  OamCycles    = 10'd80;
  localparam logic [AccW-1:0]  DrawCycles   = 10'd172;
  localparam logic [AccW-1:0]  HblankCycles = 10'd204;
  localparam logic [AccW-1:0]  LineCycles   = 10'd456;
  localparam logic [LineW-1:0] VblankLine   = 8'd144;
  localparam logic [LineW-1:0] LineCount    = 8'd154;

  // status mode encoding
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } lcd_mode_t;

  // one result beat as produced by the core
  typedef struct packed {
    logic               line_changed;
    logic               frame_done;
    logic               vblank_interrupt;
    logic               render_request;
    lcd_mode_t          mode;
    logic [LineW-1:0]   line_number;
  } lmts_res_t;

endpackage

FILE: rtl/lmts_core.sv
// lmts_core: accumulator, mode and line state with the per-tick update logic
// depends on lmts_pkg
module lmts_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         lcd_enabled,
  input  logic [lmts_pkg::CycW-1:0]    tick_cycles,
  output lmts_pkg::lmts_res_t          res
);

  logic [lmts_pkg::AccW-1:0]  acc_r, acc_nxt;
  lmts_pkg::lcd_mode_t        mode_r, mode_nxt;
  logic [lmts_pkg::LineW-1:0] line_r, line_nxt;

  logic [lmts_pkg::AccW:0]    sum_w;
  logic [lmts_pkg::AccW-1:0]  sat;
  logic [lmts_pkg::LineW-1:0] line_inc;

  assign sum_w    = {1'b0, acc_r} + {{(lmts_pkg::AccW + 1 - lmts_pkg::CycW){1'b0}}, tick_cycles};
  assign sat      = sum_w[lmts_pkg::AccW] ? lmts_pkg::AccMax : sum_w[lmts_pkg::AccW-1:0];
  assign line_inc = line_r + 8'd1;

  // next state
  always_comb begin
    acc_nxt  = acc_r;
    mode_nxt = mode_r;
    line_nxt = line_r;
    if (lcd_enabled) begin
      acc_nxt = sat;
      case (mode_r)
        lmts_pkg::MODE_OAM: begin
          if (sat >= lmts_pkg::OamCycles) begin
            acc_nxt  = sat - lmts_pkg::OamCycles;
            mode_nxt = lmts_pkg::MODE_DRAW;
          end
        end
        lmts_pkg::MODE_DRAW: begin
          if (sat >= lmts_pkg::DrawCycles) begin
            acc_nxt  = sat - lmts_pkg::DrawCycles;
            mode_nxt = lmts_pkg::MODE_HBLANK;
          end
        end
        lmts_pkg::MODE_HBLANK: begin
          if (sat >= lmts_pkg::HblankCycles) begin
            acc_nxt  = sat - lmts_pkg::HblankCycles;
            line_nxt = line_inc;
            if (line_inc == lmts_pkg::VblankLine) begin
              mode_nxt = lmts_pkg::MODE_VBLANK;
            end else begin
              mode_nxt = lmts_pkg::MODE_OAM;
            end
          end
        end
        default: begin
          if (sat >= lmts_pkg::LineCycles) begin
            acc_nxt  = sat - lmts_pkg::LineCycles;
            line_nxt = line_inc;
            if (line_inc == lmts_pkg::LineCount) begin
              line_nxt = '0;
              mode_nxt = lmts_pkg::MODE_OAM;
            end
          end
        end
      endcase
    end
  end

  // result fields: pulses on the transitions, line and mode after the tick
  always_comb begin
    res.render_request   = 1'b0;
    res.vblank_interrupt = 1'b0;
    res.frame_done       = 1'b0;
    res.line_changed     = 1'b0;
    if (lcd_enabled) begin
      case (mode_r)
        lmts_pkg::MODE_DRAW: begin
          res.render_request = (sat >= lmts_pkg::DrawCycles);
        end
        lmts_pkg::MODE_HBLANK: begin
          if (sat >= lmts_pkg::HblankCycles) begin
            res.line_changed = 1'b1;
            if (line_inc == lmts_pkg::VblankLine) begin
              res.vblank_interrupt = 1'b1;
              res.frame_done       = 1'b1;
            end
          end
        end
        lmts_pkg::MODE_VBLANK: begin
          res.line_changed = (sat >= lmts_pkg::LineCycles);
        end
        default: begin
        end
      endcase
    end
    res.line_number = line_nxt;
    res.mode        = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      mode_r <= lmts_pkg::MODE_OAM;
      line_r <= '0;
    end else if (step) begin
      acc_r  <= acc_nxt;
      mode_r <= mode_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

FILE: rtl/lcd_mode_timing_sequencer.sv
// lcd_mode_timing_sequencer: top level with input and result registers around lmts_core
// depends on lmts_pkg and lmts_core
//
// Each input beat is one tick carrying the display enable bit and the cycles
// elapsed since the last tick. While enabled, the cycles are added to a 10-bit
// saturating accumulator and at most one mode change is made per tick: oam scan
// (80) -> drawing (172) -> hblank (204) -> next line, and vblank lines (456 each)
// from line 144 through 153, wrapping to line 0. Every input beat yields
// exactly one output beat with the line and mode after the tick plus the
// render, vblank interrupt, frame done and line changed pulses. A disabled
// tick reports the current line and mode with all pulses low. A beat passes
// through the input register, then the result register, and one beat is taken
// every cycle while in_tready is high; the state update is a single add, compare
// and subtract between the input register and the result register. in_tready
// drops only while both registers hold beats and the result beat is stalled.
module lcd_mode_timing_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] lcd_enabled, [7:1] tick_cycles
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] line_number, [9:8] mode, [10] render_request,
                                  // [11] vblank_interrupt, [12] frame_done,
                                  // [13] line_changed, [15:14] zero
);

  // input register
  logic                      in_v_r;
  logic                      en_r;
  logic [lmts_pkg::CycW-1:0] cyc_r;

  // result register
  logic                      out_v_r;
  lmts_pkg::lmts_res_t       res_r;
  lmts_pkg::lmts_res_t       res_w;

  logic adv;   // result register can take a beat
  logic step;  // input register beat is processed this cycle

  assign adv       = !out_v_r || out_tready;
  assign step      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      en_r  <= in_tdata[0];
      cyc_r <= in_tdata[7:1];
    end
  end

  lmts_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .lcd_enabled (en_r),
    .tick_cycles (cyc_r),
    .res         (res_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_w;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

FILE: tb/sv/testbench.sv
// testbench: self-checking stream testbench for lcd_mode_timing_sequencer
// depends on lmts_pkg (mode encoding, widths, timing constants) and the rtl top level
// a directed table of ticks, then shaped random ticks under four idling phases, all scored
module testbench;

  localparam int ClkHalf     = 10;
  localparam int ResetCycles = 7;
  localparam int RandomTicks = 1424;    // random ticks, disabled ones included
  localparam int PhaseCount  = 4;
  localparam int CycleLimit  = 200000;  // far above the slowest correct run
  localparam int DrainCycles = 16;      // drain time after the last beat, with plenty of slack
  localparam int ReportMax   = 10;

  // one row of the directed table; fixed_exp is used only where has_fixed is set
  typedef struct {
    logic                      en;
    logic [lmts_pkg::CycW-1:0] cyc;
    logic                      has_fixed;
    lmts_pkg::lmts_res_t       fixed_exp;
  } tick_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [0] lcd_enabled, [7:1] tick_cycles
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [7:0] line_number, [9:8] mode, [10] render_request,
                                  // [11] vblank_interrupt, [12] frame_done,
                                  // [13] line_changed, [15:14] zero

  // private copy of the sequencer state, advanced once per accepted tick
  logic [lmts_pkg::AccW-1:0]  timing_acc  = '0;
  lmts_pkg::lcd_mode_t        timing_mode = lmts_pkg::MODE_OAM;
  logic [lmts_pkg::LineW-1:0] timing_line = '0;

  lmts_pkg::lmts_res_t pending_status[$];   // predicted result beats, oldest first
  tick_row_t           tick_table[$];

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int errors        = 0;
  int beats_checked = 0;
  int ticks_sent    = 0;
  int frames_seen   = 0;
  int wraps_seen    = 0;
  int cycle_count   = 0;

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  lcd_mode_timing_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // advance the private state by one tick and return the status beat it produces
  function automatic lmts_pkg::lmts_res_t step_timing(input logic en,
                                                      input logic [lmts_pkg::CycW-1:0] cyc);
    lmts_pkg::lmts_res_t r;
    int                  sum;
    r = '0;
    if (en) begin
      // saturate the sum before any threshold compare
      sum = int'(timing_acc) + int'(cyc);
      if (sum > int'(lmts_pkg::AccMax)) sum = int'(lmts_pkg::AccMax);
      timing_acc = sum[lmts_pkg::AccW-1:0];
      // at most one mode change per tick, the remainder carries over
      case (timing_mode)
        lmts_pkg::MODE_OAM: begin
          if (timing_acc >= lmts_pkg::OamCycles) begin
            timing_acc  = timing_acc - lmts_pkg::OamCycles;
            timing_mode = lmts_pkg::MODE_DRAW;
          end
        end
        lmts_pkg::MODE_DRAW: begin
          if (timing_acc >= lmts_pkg::DrawCycles) begin
            timing_acc       = timing_acc - lmts_pkg::DrawCycles;
            timing_mode      = lmts_pkg::MODE_HBLANK;
            r.render_request = 1'b1;
          end
        end
        lmts_pkg::MODE_HBLANK: begin
          if (timing_acc >= lmts_pkg::HblankCycles) begin
            timing_acc     = timing_acc - lmts_pkg::HblankCycles;
            timing_line    = timing_line + 8'd1;
            r.line_changed = 1'b1;
            // first invisible line starts vertical blank
            if (timing_line == lmts_pkg::VblankLine) begin
              timing_mode        = lmts_pkg::MODE_VBLANK;
              r.vblank_interrupt = 1'b1;
              r.frame_done       = 1'b1;
            end else begin
              timing_mode = lmts_pkg::MODE_OAM;
            end
          end
        end
        default: begin
          if (timing_acc >= lmts_pkg::LineCycles) begin
            timing_acc     = timing_acc - lmts_pkg::LineCycles;
            timing_line    = timing_line + 8'd1;
            r.line_changed = 1'b1;
            // past the last vblank line: back to line 0 in oam scan
            if (timing_line == lmts_pkg::LineCount) begin
              timing_line = '0;
              timing_mode = lmts_pkg::MODE_OAM;
            end
          end
        end
      endcase
    end
    r.line_number = timing_line;
    r.mode        = timing_mode;
    return r;
  endfunction

  // append a row to the directed table; only render_request can be set in a typed row
  task automatic add_row(input logic en, input logic [lmts_pkg::CycW-1:0] cyc,
                         input logic has_fixed, input logic [lmts_pkg::LineW-1:0] line,
                         input lmts_pkg::lcd_mode_t mode, input logic render);
    tick_row_t r;
    r.en                       = en;
    r.cyc                      = cyc;
    r.has_fixed                = has_fixed;
    r.fixed_exp                = '0;
    r.fixed_exp.line_number    = line;
    r.fixed_exp.mode           = mode;
    r.fixed_exp.render_request = render;
    tick_table.push_back(r);
  endtask

  // drive one tick beat: random idle cycles first, then hold tvalid until taken
  task automatic send_tick(input logic en, input logic [lmts_pkg::CycW-1:0] cyc,
                           input logic has_fixed, input lmts_pkg::lmts_res_t fixed_exp);
    lmts_pkg::lmts_res_t pred;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(255));   // junk while idle
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cyc, en};
    // values read right at the edge are the ones the rtl sampled
    do @(posedge clk); while (!in_tready);
    pred = step_timing(en, cyc);
    pending_status.push_back(has_fixed ? fixed_exp : pred);
    ticks_sent++;
  endtask

  // receiver back-pressure, changed only on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // scoreboard: every accepted result beat against the oldest prediction
  always @(posedge clk) begin : score
    lmts_pkg::lmts_res_t got;
    lmts_pkg::lmts_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[13:0];
      beats_checked++;
      if (got.frame_done) frames_seen++;
      if (got.line_changed && got.line_number == 0) wraps_seen++;
      if (pending_status.size() == 0) begin
        if (errors < ReportMax)
          $display("error: result beat %0d arrived with no tick pending (data %h)",
                   beats_checked, out_tdata);
        errors++;
      end else begin
        want = pending_status.pop_front();
        if (got.line_number !== want.line_number || got.mode !== want.mode ||
            got.render_request !== want.render_request ||
            got.vblank_interrupt !== want.vblank_interrupt ||
            got.frame_done !== want.frame_done ||
            got.line_changed !== want.line_changed) begin
          if (errors < ReportMax) begin
            $write("error: beat %0d got line %0d mode %0d rr %b vi %b fd %b lc %b,",
                   beats_checked, got.line_number, got.mode, got.render_request,
                   got.vblank_interrupt, got.frame_done, got.line_changed);
            $display(" want line %0d mode %0d rr %b vi %b fd %b lc %b",
                     want.line_number, want.mode, want.render_request,
                     want.vblank_interrupt, want.frame_done, want.line_changed);
          end
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats still pending",
               cycle_count, pending_status.size());
      $display("** lcd_mode_timing_sequencer: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    tick_row_t                 r;
    logic [lmts_pkg::CycW-1:0] cyc;
    int                        phase;
    int                        n;

    // directed table; typed rows are the ones that follow from reset at a glance
    add_row(1'b0, 7'd64, 1'b1, 8'd0, lmts_pkg::MODE_OAM,    1'b0);  // disabled after reset
    add_row(1'b1, 7'd0,  1'b1, 8'd0, lmts_pkg::MODE_OAM,    1'b0);  // enabled, zero cycles
    add_row(1'b1, 7'd64, 1'b1, 8'd0, lmts_pkg::MODE_OAM,    1'b0);  // tick of 64, still below oam
    add_row(1'b1, 7'd16, 1'b1, 8'd0, lmts_pkg::MODE_DRAW,   1'b0);  // exactly reaches oam length
    add_row(1'b0, 7'd63, 1'b1, 8'd0, lmts_pkg::MODE_DRAW,   1'b0);  // disabled while drawing
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_DRAW,   1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_DRAW,   1'b0);
    add_row(1'b1, 7'd43, 1'b0, 8'd0, lmts_pkg::MODE_DRAW,   1'b0);  // one short of drawing end
    add_row(1'b1, 7'd1,  1'b1, 8'd0, lmts_pkg::MODE_HBLANK, 1'b1);  // drawing ends, render pulse
    add_row(1'b1, 7'd2,  1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);  // single-bit ticks for bits 1, 2, 3, 5 and 6
    add_row(1'b1, 7'd4,  1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd8,  1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd32, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);  // hblank ends, line 1
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);
    add_row(1'b1, 7'd64, 1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);  // second line change
    add_row(1'b0, 7'd0,  1'b0, 8'd0, lmts_pkg::MODE_HBLANK, 1'b0);  // disabled, zero cycles

    // single reset at the start of the run
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (tick_table[i]) begin
      r = tick_table[i];
      send_tick(r.en, r.cyc, r.has_fixed, r.fixed_exp);
    end

    // random ticks: mostly counts of 56 to 64 so the run gets through a whole
    // frame, into vblank and across the wrap; some counts of 0 to 64 and
    // disabled ticks mixed in
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      n = 0;
      while (n < RandomTicks / PhaseCount) begin
        if ($urandom_range(9) == 0) begin
          cyc = 7'($urandom_range(64));
          send_tick(1'b0, cyc, 1'b0, '0);
        end else begin
          if ($urandom_range(99) < 85) cyc = 7'($urandom_range(64, 56));
          else cyc = 7'($urandom_range(64));
          send_tick(1'b1, cyc, 1'b0, '0);
        end
        n++;
      end
    end

    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("ran %0d ticks through four idling phases, %0d result beats scored",
             ticks_sent, beats_checked);
    $display("saw %0d frame-done pulses and %0d wraps to line 0, %0d errors",
             frames_seen, wraps_seen, errors);
    if (errors == 0) begin
      $display("** lcd_mode_timing_sequencer: PASSED **");
    end else begin
      $display("** lcd_mode_timing_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
